// ===== sv/can_link_health_supervisor_macros.svh =====
// Assertion macros shared by the checker of the CAN link health supervisor.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CAN_LINK_HEALTH_SUPERVISOR_MACROS_SVH
`define CAN_LINK_HEALTH_SUPERVISOR_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CLHS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CLHS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/clhs_pkg.sv =====
// Package of the CAN link health supervisor: command codes, register map,
// request, result and configuration types. No dependencies.
package clhs_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 136;

   localparam logic [15:0] RECOVERY_DELAY_RESET = 16'd1000;
   localparam logic [15:0] STUCK_LIMIT_RESET = 16'd100;

   typedef enum logic [1:0] {
      CMD_POLL  = 2'd0,
      CMD_ERROR = 2'd1,
      CMD_START = 2'd2
   } cmd_type;

   // Register index, taken from the word address bit of paddr.
   typedef enum logic {
      REG_RECOVERY_DELAY = 1'b0,
      REG_STUCK_LIMIT    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [15:0] recovery_delay_ms;
      logic [15:0] stuck_limit_ms;
   } cfg_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] now_ms;
      logic        bus_off;
      logic        mailboxes_full;
      logic        listening;
      logic        init_ack;
      logic        restart_ok;
      logic [31:0] error_code;
      logic        error_is_bus_off;
   } req_type;

   typedef struct packed {
      logic        ready_res;
      logic        restart_request;
      logic        recovery_waiting;
      logic [31:0] bus_off_total;
      logic [31:0] restart_total;
      logic [31:0] error_total;
      logic [31:0] latest_error;
   } rsp_type;

endpackage

// ===== sv/clhs_csr.sv =====
// Configuration registers of the CAN link health supervisor, APB-style port.
// Depends on clhs_pkg.
module clhs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [clhs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [clhs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [clhs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output clhs_pkg::cfg_type               cfg
);
   import clhs_pkg::*;

   logic [15:0]   recovery_delay_ff;
   logic [15:0]   recovery_delay_in;
   logic [15:0]   stuck_limit_ff;
   logic [15:0]   stuck_limit_in;
   logic          wr_en;
   reg_index_type reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);

   always_comb begin
      recovery_delay_in = recovery_delay_ff;
      stuck_limit_in = stuck_limit_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_RECOVERY_DELAY: recovery_delay_in = csr_pwdata[15:0];
            REG_STUCK_LIMIT:    stuck_limit_in = csr_pwdata[15:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_RECOVERY_DELAY: csr_prdata = {16'd0, recovery_delay_ff};
         REG_STUCK_LIMIT:    csr_prdata = {16'd0, stuck_limit_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recovery_delay_ff <= RECOVERY_DELAY_RESET;
         stuck_limit_ff <= STUCK_LIMIT_RESET;
      end else begin
         recovery_delay_ff <= recovery_delay_in;
         stuck_limit_ff <= stuck_limit_in;
      end
   end

   assign cfg.recovery_delay_ms = recovery_delay_ff;
   assign cfg.stuck_limit_ms = stuck_limit_ff;

endmodule

// ===== sv/clhs_core.sv =====
// Supervisor state and the per-request decision logic of the CAN link health
// supervisor. Depends on clhs_pkg.
module clhs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  clhs_pkg::req_type req,
   input  clhs_pkg::cfg_type cfg,
   output clhs_pkg::rsp_type rsp
);
   import clhs_pkg::*;

   logic        ready_ff, ready_in;
   logic        pending_ff, pending_in;
   logic [31:0] due_ff, due_in;
   logic        armed_ff, armed_in;
   logic [31:0] since_ff, since_in;
   logic [31:0] boff_cnt_ff, boff_cnt_in;
   logic [31:0] rst_cnt_ff, rst_cnt_in;
   logic [31:0] err_cnt_ff, err_cnt_in;
   logic [31:0] last_err_ff, last_err_in;

   logic [31:0] due_diff;
   logic        due_reached;
   logic [31:0] busy_elapsed;
   logic        stuck_hit;
   logic [31:0] next_due;
   logic        stuck;
   logic        restart;

   // The due time has come when now - due is not negative as a signed value.
   assign due_diff = req.now_ms - due_ff;
   assign due_reached = ~due_diff[31];
   assign busy_elapsed = req.now_ms - since_ff;
   assign stuck_hit = busy_elapsed >= {16'd0, cfg.stuck_limit_ms};
   assign next_due = req.now_ms + {16'd0, cfg.recovery_delay_ms};
   assign stuck = ready_ff && req.mailboxes_full && armed_ff && stuck_hit;

   always_comb begin
      ready_in = ready_ff;
      pending_in = pending_ff;
      due_in = due_ff;
      armed_in = armed_ff;
      since_in = since_ff;
      boff_cnt_in = boff_cnt_ff;
      rst_cnt_in = rst_cnt_ff;
      err_cnt_in = err_cnt_ff;
      last_err_in = last_err_ff;
      restart = 1'b0;
      unique case (req.command)
         CMD_POLL: begin
            priority if (pending_ff) begin
               if (due_reached) begin
                  pending_in = 1'b0;
                  restart = 1'b1;
               end
            end else if (req.bus_off) begin
               boff_cnt_in = boff_cnt_ff + 32'd1;
               ready_in = 1'b0;
               pending_in = 1'b1;
               due_in = next_due;
            end else if (ready_ff) begin
               if (req.mailboxes_full) begin
                  if (!armed_ff) begin
                     armed_in = 1'b1;
                     since_in = req.now_ms;
                  end
               end else begin
                  armed_in = 1'b0;
               end
               if (stuck || !req.listening || req.init_ack) begin
                  restart = 1'b1;
               end
            end
            // A forced restart disarms the mailbox timer; its outcome
            // either restores the link or schedules the next attempt.
            if (restart) begin
               armed_in = 1'b0;
               if (req.restart_ok) begin
                  ready_in = 1'b1;
                  rst_cnt_in = rst_cnt_ff + 32'd1;
               end else begin
                  ready_in = 1'b0;
                  pending_in = 1'b1;
                  due_in = next_due;
               end
            end
         end
         CMD_ERROR: begin
            err_cnt_in = err_cnt_ff + 32'd1;
            last_err_in = req.error_code;
            // A bus-off while a recovery is already pending is not counted.
            if (req.error_is_bus_off && !pending_ff) begin
               boff_cnt_in = boff_cnt_ff + 32'd1;
               ready_in = 1'b0;
               pending_in = 1'b1;
               due_in = next_due;
            end
         end
         CMD_START: begin
            if (req.restart_ok) begin
               ready_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         pending_ff <= 1'b0;
         due_ff <= '0;
         armed_ff <= 1'b0;
         since_ff <= '0;
         boff_cnt_ff <= '0;
         rst_cnt_ff <= '0;
         err_cnt_ff <= '0;
         last_err_ff <= '0;
      end else if (step_en) begin
         ready_ff <= ready_in;
         pending_ff <= pending_in;
         due_ff <= due_in;
         armed_ff <= armed_in;
         since_ff <= since_in;
         boff_cnt_ff <= boff_cnt_in;
         rst_cnt_ff <= rst_cnt_in;
         err_cnt_ff <= err_cnt_in;
         last_err_ff <= last_err_in;
      end
   end

   assign rsp.ready_res = ready_in;
   assign rsp.restart_request = restart;
   assign rsp.recovery_waiting = pending_in;
   assign rsp.bus_off_total = boff_cnt_in;
   assign rsp.restart_total = rst_cnt_in;
   assign rsp.error_total = err_cnt_in;
   assign rsp.latest_error = last_err_in;

endmodule

// ===== sv/can_link_health_supervisor.sv =====
// Top level of the CAN link health supervisor: request and result registers
// around the decision core, plus the configuration port.
// Depends on clhs_pkg, clhs_csr and clhs_core.
//
//   Channel   Direction  Handshake                Carries
//   req_*     in         tvalid/tready            one poll, error or start request
//   rsp_*     out        tvalid/tready            one status result per request
//   csr_*     in/out     psel/penable/pready      two 16-bit delay registers
//
// A request is captured in the request register, evaluated by the core once
// the result register is empty or draining, and written to the result register
// together with the state. The result is offered only after it has passed the
// request register and the result register; one request per cycle is sustained
// while the result side accepts, set by the single state update in the core.
// A stalled result holds in the result register while one more request waits
// in the request register; req_tready drops only when both are occupied.
// Reset is synchronous and active high; it clears the state, the counters
// and both valid flags, and restores the register defaults.
module can_link_health_supervisor (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata, from bit 0: now_ms[31:0], bus_off, mailboxes_full, listening,
   // init_ack, restart_ok, error_code[31:0], error_is_bus_off, zero fill.
   input  logic [clhs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: command[1:0].
   input  logic [clhs_pkg::REQ_TUSER_W-1:0] req_tuser,
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata, from bit 0: ready_res, restart_request, recovery_waiting,
   // bus_off_total[31:0], restart_total[31:0], error_total[31:0],
   // latest_error[31:0], zero fill.
   output logic [clhs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [clhs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [clhs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [clhs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import clhs_pkg::*;

   req_type req_unpacked;
   req_type req_ff;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_core;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    req_fire;
   logic    step_en;
   cfg_type cfg;

   // Unpack the request fields from the bus.
   assign req_unpacked.command = cmd_type'(req_tuser);
   assign req_unpacked.now_ms = req_tdata[31:0];
   assign req_unpacked.bus_off = req_tdata[32];
   assign req_unpacked.mailboxes_full = req_tdata[33];
   assign req_unpacked.listening = req_tdata[34];
   assign req_unpacked.init_ack = req_tdata[35];
   assign req_unpacked.restart_ok = req_tdata[36];
   assign req_unpacked.error_code = req_tdata[68:37];
   assign req_unpacked.error_is_bus_off = req_tdata[69];

   // The held request moves on when the result register is empty or is being
   // drained in this cycle; a new request may enter in the same cycle.
   assign step_en = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || step_en;
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_fire) begin
         req_valid_in = 1'b1;
      end else if (step_en) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_unpacked;
      end
      if (step_en) begin
         rsp_ff <= rsp_core;
      end
   end

   clhs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   clhs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_core)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, rsp_ff.latest_error, rsp_ff.error_total,
                       rsp_ff.restart_total, rsp_ff.bus_off_total,
                       rsp_ff.recovery_waiting, rsp_ff.restart_request,
                       rsp_ff.ready_res};

endmodule

// ===== sv/clhs_checker.sv =====
// Port-level checker of the CAN link health supervisor and its bind.
// Depends on clhs_pkg and can_link_health_supervisor_macros.svh.
`include "can_link_health_supervisor_macros.svh"

module clhs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [clhs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import clhs_pkg::*;

   logic rsp_ready_res;
   logic rsp_restart;
   logic rsp_waiting;

   assign rsp_ready_res = rsp_tdata[0];
   assign rsp_restart = rsp_tdata[1];
   assign rsp_waiting = rsp_tdata[2];

   // No result is offered in the cycle after reset.
   `CLHS_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // A stalled result keeps its contents.
   `CLHS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // A request taken while the result side is empty shows up after the request and result registers.
   `CLHS_ASSERT(a_rsp_latency, clock, reset, req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid, "result missing after request")

   // A failed restart always leaves a recovery scheduled.
   `CLHS_ASSERT(a_failed_restart_waits, clock, reset, rsp_tvalid && rsp_restart && !rsp_ready_res |-> rsp_waiting, "failed restart without recovery")

endmodule

bind can_link_health_supervisor clhs_checker u_clhs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/can_link_health_supervisor_test.sv =====
// Self-checking test of the CAN link health supervisor: a directed opening,
// then randomized phases under several register settings and idling patterns.
// Depends on clhs_pkg and the can_link_health_supervisor RTL.
module can_link_health_supervisor_test;
   import clhs_pkg::*;

   // The command field has one encoding that the block must treat as a no-op.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Poll status flags, packed as {bus_off, mailboxes_full, listening,
   // init_ack, restart_ok} when building requests.
   localparam logic [4:0] F_BOFF = 5'b10000;
   localparam logic [4:0] F_FULL = 5'b01000;
   localparam logic [4:0] F_LSN  = 5'b00100;
   localparam logic [4:0] F_INIT = 5'b00010;
   localparam logic [4:0] F_OK   = 5'b00001;

   localparam int PHASE_ITEMS = 165;
   localparam int HOLD_CYCLES = 400;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   can_link_health_supervisor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Requests waiting to be offered, and the status words that the accepted
   // requests must produce, oldest first.
   req_type req_backlog[$];
   rsp_type predicted_status[$];
   req_type offered;

   int issued_count = 0;
   int checked_count = 0;
   int mismatches = 0;

   // Idling controls, in percent of cycles, plus the long receiver hold-off.
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left;
   logic hold_start = 1'b0;

   // Time cursor used to build plausible timestamp sequences.
   logic [31:0] stamp_ms;

   // Shadow of the supervisor: configuration and decision state.
   logic [15:0] delay_ms = RECOVERY_DELAY_RESET;
   logic [15:0] stuck_ms = STUCK_LIMIT_RESET;
   logic        link_ready = 1'b0;
   logic        recov_pending = 1'b0;
   logic [31:0] recov_due = '0;
   logic        full_armed = 1'b0;
   logic [31:0] full_since = '0;
   logic [31:0] busoff_tally = '0;
   logic [31:0] restart_count = '0;
   logic [31:0] err_count = '0;
   logic [31:0] err_latched = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // A bus-off report arms a delayed recovery, unless one is already armed;
   // in that case neither the count nor the due time moves.
   function automatic void begin_recovery(logic [31:0] now);
      if (!recov_pending) begin
         busoff_tally = busoff_tally + 32'd1;
         link_ready = 1'b0;
         recov_pending = 1'b1;
         recov_due = now + {16'b0, delay_ms};
      end
   endfunction

   // A forced restart always disarms the mailbox timer. Success brings the
   // link back and is counted; failure arms another recovery attempt.
   function automatic void restart_link(logic [31:0] now, logic ok);
      full_armed = 1'b0;
      link_ready = ok;
      if (ok) begin
         restart_count = restart_count + 32'd1;
      end else begin
         recov_pending = 1'b1;
         recov_due = now + {16'b0, delay_ms};
      end
   endfunction

   function automatic rsp_type next_status(req_type r);
      rsp_type     s;
      logic        fired;
      logic        stuck;
      logic [31:0] past_due;
      logic [31:0] full_for;
      fired = 1'b0;
      stuck = 1'b0;
      past_due = r.now_ms - recov_due;
      full_for = r.now_ms - full_since;
      case (r.command)
         CMD_POLL: begin
            if (recov_pending) begin
               // Wrap-safe: due once the signed distance is not negative.
               if (!past_due[31]) begin
                  recov_pending = 1'b0;
                  restart_link(r.now_ms, r.restart_ok);
                  fired = 1'b1;
               end
            end else if (r.bus_off) begin
               begin_recovery(r.now_ms);
            end else if (link_ready) begin
               if (r.mailboxes_full) begin
                  if (!full_armed) begin
                     full_armed = 1'b1;
                     full_since = r.now_ms;
                  end else if (full_for >= {16'b0, stuck_ms}) begin
                     stuck = 1'b1;
                  end
               end else begin
                  full_armed = 1'b0;
               end
               if (stuck || !r.listening || r.init_ack) begin
                  restart_link(r.now_ms, r.restart_ok);
                  fired = 1'b1;
               end
            end
         end
         CMD_ERROR: begin
            err_count = err_count + 32'd1;
            err_latched = r.error_code;
            if (r.error_is_bus_off) begin
               begin_recovery(r.now_ms);
            end
         end
         CMD_START: begin
            // A failed start leaves the ready flag as it was.
            if (r.restart_ok) begin
               link_ready = 1'b1;
            end
         end
         default: begin
            // The unused command only reports the state.
         end
      endcase
      s.ready_res = link_ready;
      s.restart_request = fired;
      s.recovery_waiting = recov_pending;
      s.bus_off_total = busoff_tally;
      s.restart_total = restart_count;
      s.error_total = err_count;
      s.latest_error = err_latched;
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------

   // The prediction is made at the edge where a request is accepted, so the
   // shadow state advances in the same order as the block's own state.
   // A request that is still offered keeps tvalid high; a new one is loaded
   // only when the slot is free or is being taken at this edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_status.push_back(next_status(offered));
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, offered.error_is_bus_off, offered.error_code,
                             offered.restart_ok, offered.init_ack, offered.listening,
                             offered.mailboxes_full, offered.bus_off, offered.now_ms};
               req_tuser <= offered.command;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor
   // ---------------------------------------------------------------------

   task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         mismatches++;
      end
   endtask

   // Each accepted status word is compared with the oldest prediction. The
   // receiver stalls at random, and throughout while a hold-off runs.
   always @(posedge clock) begin : status_monitor
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (predicted_status.size() == 0) begin
               $error("status word %0h arrived with no request outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = predicted_status.pop_front();
               check_field("ready_res", 32'(want.ready_res), 32'(rsp_tdata[0]));
               check_field("restart_request", 32'(want.restart_request),
                           32'(rsp_tdata[1]));
               check_field("recovery_waiting", 32'(want.recovery_waiting),
                           32'(rsp_tdata[2]));
               check_field("bus_off_total", want.bus_off_total, rsp_tdata[34:3]);
               check_field("restart_total", want.restart_total, rsp_tdata[66:35]);
               check_field("error_total", want.error_total, rsp_tdata[98:67]);
               check_field("latest_error", want.latest_error, rsp_tdata[130:99]);
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long receiver hold-off, counted here so the sender keeps offering and
   // the block has to fill both of its registers and push back.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type make_req(logic [1:0] cmd, logic [31:0] now,
                                        logic [4:0] flags, logic [31:0] code,
                                        logic eboff);
      req_type r;
      r.command = cmd_type'(cmd);
      r.now_ms = now;
      {r.bus_off, r.mailboxes_full, r.listening, r.init_ack, r.restart_ok} = flags;
      r.error_code = code;
      r.error_is_bus_off = eboff;
      return r;
   endfunction

   function automatic logic chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   task automatic queue_req(req_type r);
      req_backlog.push_back(r);
      issued_count++;
   endtask

   // Mostly well-formed traffic: time moves forward in steps on the scale of
   // the current delays so recoveries and the mailbox timer actually expire.
   // A few requests are pure noise, unused commands or jumps in time.
   task automatic queue_random(int count);
      int          span;
      int          roll;
      logic [4:0]  flags;
      span = ((delay_ms > stuck_ms) ? int'(delay_ms) : int'(stuck_ms)) / 3 + 4;
      stamp_ms = $urandom;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (chance(2)) begin
            stamp_ms = $urandom;
         end else begin
            stamp_ms = stamp_ms + $urandom_range(span, 0);
         end
         if (roll < 4) begin
            queue_req(make_req(2'($urandom_range(3)), $urandom, 5'($urandom_range(31)),
                               $urandom, 1'($urandom_range(1))));
         end else if (roll < 6) begin
            queue_req(make_req(CMD_UNUSED, stamp_ms, 5'($urandom_range(31)),
                               $urandom, 1'($urandom_range(1))));
         end else if (roll < 16) begin
            queue_req(make_req(CMD_ERROR, stamp_ms, 5'($urandom_range(31)),
                               $urandom, chance(25)));
         end else if (roll < 24) begin
            queue_req(make_req(CMD_START, stamp_ms,
                               {4'($urandom_range(15)), chance(75)},
                               $urandom, 1'($urandom_range(1))));
         end else begin
            flags = {chance(4), chance(50), chance(92), chance(4), chance(80)};
            queue_req(make_req(CMD_POLL, stamp_ms, flags, $urandom,
                               1'($urandom_range(1))));
         end
      end
   endtask

   // Directed opening at the reset register values (delay 1000, limit 100).
   task automatic queue_directed();
      // Polls before any start do nothing; the unused command is inert.
      queue_req(make_req(CMD_POLL, 32'h0, F_LSN, 32'h0, 1'b0));
      queue_req(make_req(CMD_UNUSED, 32'hFFFF_FFFF, 5'h1F, 32'hFFFF_FFFF, 1'b1));
      // A failed start leaves the link down, a good one brings it up.
      queue_req(make_req(CMD_START, 32'd1, 5'h0, 32'h0, 1'b0));
      queue_req(make_req(CMD_START, 32'd2, F_OK, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'd3, F_LSN, 32'h0, 1'b0));
      // Mailboxes full: arm at 10, one short of the limit at 109, stuck at 110.
      queue_req(make_req(CMD_POLL, 32'd10, F_FULL | F_LSN, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'd109, F_FULL | F_LSN, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'd110, F_FULL | F_LSN | F_OK, 32'h0, 1'b0));
      // Not listening, and the restart fails: recovery due at 1120.
      queue_req(make_req(CMD_POLL, 32'd120, 5'h0, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'd1119, F_OK, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'd1120, F_BOFF | F_OK, 32'h0, 1'b0));
      // Init acknowledge forces a restart.
      queue_req(make_req(CMD_POLL, 32'd1130, F_LSN | F_INIT | F_OK, 32'h0, 1'b0));
      // Error events; the second bus-off report is not counted again.
      queue_req(make_req(CMD_ERROR, 32'd1140, 5'h1F, 32'hFFFF_FFFF, 1'b0));
      queue_req(make_req(CMD_ERROR, 32'd1150, 5'h0, 32'h0, 1'b1));
      queue_req(make_req(CMD_ERROR, 32'd1160, 5'h0, 32'hA5A5_A5A5, 1'b1));
      queue_req(make_req(CMD_POLL, 32'd1170, F_BOFF | F_LSN, 32'h0, 1'b0));
      // A start while recovery is pending raises ready without clearing it.
      queue_req(make_req(CMD_START, 32'd1180, F_OK, 32'h0, 1'b0));
      // Recovery fires at 2150 and fails, then succeeds at 3150.
      queue_req(make_req(CMD_POLL, 32'd2150, F_LSN, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'd3150, F_OK, 32'h0, 1'b0));
      // Bus-off just before the timestamp wraps; the due time wraps to 0x2E8.
      queue_req(make_req(CMD_POLL, 32'hFFFF_FF00, F_BOFF, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'hFFFF_FFFF, F_LSN | F_OK, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'h0000_02E8, F_LSN | F_OK, 32'h0, 1'b0));
      // Mailbox timer arms, then disarms as soon as a mailbox frees up.
      queue_req(make_req(CMD_POLL, 32'h0000_0300, F_FULL | F_LSN, 32'h0, 1'b0));
      queue_req(make_req(CMD_POLL, 32'h0000_0301, F_LSN, 32'h0, 1'b0));
   endtask

   // Register write: setup cycle, then access until pready. The shadow copy
   // changes at the same edge as the block's register.
   task automatic csr_write(reg_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_RECOVERY_DELAY: delay_ms = value;
         REG_STUCK_LIMIT:    stuck_ms = value;
      endcase
   endtask

   task automatic set_idling(int send_pct, int rsp_pct);
      @(posedge clock);
      send_idle_pct <= send_pct;
      stall_pct <= rsp_pct;
   endtask

   // Every request produces exactly one status word, so the block is idle
   // once all issued requests have been checked and its pipeline has drained.
   task automatic await_quiet();
      while (checked_count != issued_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset register values, no idling on either side.
      queue_directed();
      queue_random(PHASE_ITEMS);
      await_quiet();

      for (int p = 1; p <= 5; p++) begin
         case (p)
            1: begin
               csr_write(REG_RECOVERY_DELAY, 16'd0);
               csr_write(REG_STUCK_LIMIT, 16'd0);
               set_idling(74, 0);
            end
            2: begin
               csr_write(REG_RECOVERY_DELAY, 16'hFFFF);
               csr_write(REG_STUCK_LIMIT, 16'hFFFF);
               set_idling(0, 74);
            end
            3: begin
               csr_write(REG_RECOVERY_DELAY, 16'($urandom_range(300, 1)));
               csr_write(REG_STUCK_LIMIT, 16'($urandom_range(300, 1)));
               set_idling(29, 29);
            end
            4: begin
               csr_write(REG_RECOVERY_DELAY, 16'($urandom_range(16'hFFFF)));
               csr_write(REG_STUCK_LIMIT, 16'($urandom_range(16'hFFFF)));
               set_idling(0, 0);
            end
            default: begin
               csr_write(REG_RECOVERY_DELAY, 16'd1);
               csr_write(REG_STUCK_LIMIT, 16'hFFFF);
               set_idling(74, 74);
            end
         endcase
         queue_random(PHASE_ITEMS);
         if (p == 2) begin
            // Hold the result side off while requests keep coming.
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         await_quiet();
      end

      repeat (8) @(posedge clock);
      if (predicted_status.size() != 0) begin
         $error("%0d predicted status words never arrived", predicted_status.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
